@@ rtl/packet_reorder_hold_buffer_core_macros.svh @@
// Assertion macros for the packet reorder hold buffer.
// Has no dependencies; included by the top level only.
`ifndef PACKET_REORDER_HOLD_BUFFER_CORE_MACROS_SVH
`define PACKET_REORDER_HOLD_BUFFER_CORE_MACROS_SVH
`ifndef SYNTH
`define PRHB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PRHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRHB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PRHB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/prhb_pkg.sv @@
// Types, constants and state codes of the packet reorder hold buffer.
// Has no dependencies; used by the top level.
`default_nettype none
package prhb_pkg;
    localparam int MAX_HELD = 64;
    localparam int IDX_BITS = $clog2(MAX_HELD);
    localparam int CNT_BITS = $clog2(MAX_HELD + 1);
    localparam int TAG_BITS = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int RNG_BITS = 32;
    localparam int BIT_CNT_BITS = $clog2(RNG_BITS);

    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_POLL = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_IN_EN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_EN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANCE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED = 3'd5;

    typedef struct packed {
        logic [1:0] cmd;
        logic [TAG_BITS-1:0] packet_tag;
        logic is_outbound;
        logic [13:0] capture_roll;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic has_packet;
        logic [TAG_BITS-1:0] out_tag;
        logic out_outbound;
        logic from_hold;
        logic still_holding;
        logic last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RNG,
        ST_MOD,
        ST_RD_SWAP,
        ST_WR_I,
        ST_WR_J,
        ST_RD_OUT,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/packet_reorder_hold_buffer_core.sv @@
// Packet reorder hold buffer: hold store, shuffle sequencer and outputs.
// Depends on prhb_pkg and packet_reorder_hold_buffer_core_macros.svh.
//
// Commands enter on i_in when start is high and busy is low. Each result
// appears on o_out for one cycle with o_valid high; the receiver cannot stall.
// An arrival, a poll that releases nothing, an empty flush and an unknown
// command give one result in the next cycle and leave busy low, so such
// items can be issued every cycle.
// A releasing poll with n held packets first shuffles the store with n-1
// swaps, each index drawn by a bit-serial remainder unit from an xorshift
// draw. Packets then leave one at a time, each read through
// the registered store read port, the last one marked by o_out.last.
// A flush of n packets gives n results, oldest first.
// busy is high from the cycle after a release or flush starts until the
// last result appears; it is low again in the cycle of the last result.
// Configuration writes on i_cfg_we take effect at the next edge and must be
// made while busy is low.
// Reset clears the held count and the hold time, loads the registers with
// their defaults and the generator with seed 1. Store contents are not reset.
`default_nettype none
`include "packet_reorder_hold_buffer_core_macros.svh"
module packet_reorder_hold_buffer_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire prhb_pkg::t_in_item i_in,
    output logic busy,
    output logic o_valid,
    output prhb_pkg::t_out_item o_out,
    input  wire logic i_cfg_we,
    input  wire logic [prhb_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [prhb_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import prhb_pkg::*;

    logic [TAG_BITS:0] r_mem [MAX_HELD];
    logic [TAG_BITS:0] r_rd_a, r_rd_b;

    t_state r_state, n_state;
    logic r_in_en, r_out_en;
    logic [13:0] r_chance;
    logic [6:0] r_limit;
    logic [10:0] r_delay;
    logic [RNG_BITS-1:0] r_rng, n_rng;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [31:0] r_oldest, n_oldest;
    logic [IDX_BITS-1:0] r_i, n_i, r_j, n_j;
    logic [CNT_BITS-1:0] r_left, n_left, r_n, n_n;
    logic r_flush, n_flush;
    logic [RNG_BITS-1:0] r_dvd, n_dvd;
    logic [IDX_BITS-1:0] r_mr, n_mr;
    logic [BIT_CNT_BITS-1:0] r_bit, n_bit;
    logic r_valid, n_valid;
    t_out_item r_out, n_out;

    logic accept, enabled, capture, release_now;
    logic [CNT_BITS-1:0] eff_limit;
    logic [31:0] age;
    logic [RNG_BITS-1:0] rng_x;
    logic [IDX_BITS:0] mod_t, mod_d;
    logic mem_we;
    logic [IDX_BITS-1:0] mem_waddr;
    logic [TAG_BITS:0] mem_wdata;
    logic rd_en;
    logic [IDX_BITS-1:0] rd_addr_a;

    always_comb begin
        accept = start && (r_state == ST_IDLE);
        eff_limit = (r_limit > 7'(MAX_HELD)) ? CNT_BITS'(MAX_HELD) : CNT_BITS'(r_limit);
        enabled = i_in.is_outbound ? r_out_en : r_in_en;
        capture = (r_count < eff_limit) && enabled && (i_in.capture_roll < r_chance);
        age = i_in.now_ms - r_oldest;
        release_now = (r_count != '0) && ((r_count >= eff_limit) || (age >= 32'(r_delay)));
        rng_x = r_rng ^ (r_rng << 13);
        rng_x = rng_x ^ (rng_x >> 17);
        rng_x = rng_x ^ (rng_x << 5);
        mod_t = {r_mr, r_dvd[RNG_BITS-1]};
        mod_d = {1'b0, r_i} + (IDX_BITS+1)'(1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.cmd == CMD_POLL) && release_now) begin
                    n_state = (r_count == CNT_BITS'(1)) ? ST_RD_OUT : ST_RNG;
                end else if (accept && (i_in.cmd == CMD_FLUSH) && (r_count != '0)) begin
                    n_state = ST_RD_OUT;
                end
            end
            ST_RNG: n_state = ST_MOD;
            ST_MOD: n_state = (r_bit == '0) ? ST_RD_SWAP : ST_MOD;
            ST_RD_SWAP: n_state = ST_WR_I;
            ST_WR_I: n_state = ST_WR_J;
            ST_WR_J: n_state = (r_i == IDX_BITS'(1)) ? ST_RD_OUT : ST_RNG;
            ST_RD_OUT: n_state = ST_EMIT;
            ST_EMIT: n_state = (r_left == CNT_BITS'(1)) ? ST_IDLE : ST_RD_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_rng = r_rng;
        if (i_cfg_we && (i_cfg_idx == REG_SEED)) begin
            n_rng = i_cfg_data[RNG_BITS-1:0];
        end
        n_count = r_count;
        n_oldest = r_oldest;
        n_i = r_i;
        n_j = r_j;
        n_left = r_left;
        n_n = r_n;
        n_flush = r_flush;
        n_dvd = r_dvd;
        n_mr = r_mr;
        n_bit = r_bit;
        n_valid = 1'b0;
        n_out = '0;
        mem_we = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_rd_b;
        rd_en = 1'b0;
        rd_addr_a = r_i;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    n_out.last = 1'b1;
                    n_out.still_holding = (r_count != '0);
                    case (i_in.cmd)
                        CMD_ARRIVE: begin
                            if (capture) begin
                                if (r_count == '0) begin
                                    n_oldest = i_in.now_ms;
                                end
                                mem_we = 1'b1;
                                mem_waddr = r_count[IDX_BITS-1:0];
                                mem_wdata = {i_in.is_outbound, i_in.packet_tag};
                                n_count = r_count + CNT_BITS'(1);
                                n_out.still_holding = 1'b1;
                            end else begin
                                n_out.has_packet = 1'b1;
                                n_out.out_tag = i_in.packet_tag;
                                n_out.out_outbound = i_in.is_outbound;
                            end
                        end
                        CMD_POLL: begin
                            if (release_now) begin
                                n_valid = 1'b0;
                                n_count = '0;
                                n_n = r_count;
                                n_left = r_count;
                                n_flush = 1'b0;
                                n_i = IDX_BITS'(r_count - CNT_BITS'(1));
                            end
                        end
                        CMD_FLUSH: begin
                            if (r_count != '0) begin
                                n_valid = 1'b0;
                                n_count = '0;
                                n_left = r_count;
                                n_flush = 1'b1;
                                n_i = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RNG: begin
                n_rng = rng_x;
                n_dvd = rng_x;
                n_mr = '0;
                n_bit = BIT_CNT_BITS'(RNG_BITS - 1);
            end
            ST_MOD: begin
                n_mr = (mod_t >= mod_d) ? IDX_BITS'(mod_t - mod_d) : IDX_BITS'(mod_t);
                n_dvd = r_dvd << 1;
                n_bit = r_bit - BIT_CNT_BITS'(1);
                if (r_bit == '0) begin
                    n_j = (mod_t >= mod_d) ? IDX_BITS'(mod_t - mod_d) : IDX_BITS'(mod_t);
                end
            end
            ST_RD_SWAP: rd_en = 1'b1;
            ST_WR_I: begin
                mem_we = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_rd_b;
            end
            ST_WR_J: begin
                mem_we = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_rd_a;
                n_i = (r_i == IDX_BITS'(1)) ? IDX_BITS'(r_n - CNT_BITS'(1))
                                             : r_i - IDX_BITS'(1);
            end
            ST_RD_OUT: rd_en = 1'b1;
            ST_EMIT: begin
                n_valid = 1'b1;
                n_out.has_packet = 1'b1;
                n_out.out_tag = r_rd_a[TAG_BITS-1:0];
                n_out.out_outbound = r_rd_a[TAG_BITS];
                n_out.from_hold = 1'b1;
                n_out.last = (r_left == CNT_BITS'(1));
                n_left = r_left - CNT_BITS'(1);
                n_i = r_flush ? r_i + IDX_BITS'(1) : r_i - IDX_BITS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_left <= n_left;
        r_n <= n_n;
        r_flush <= n_flush;
        r_dvd <= n_dvd;
        r_mr <= n_mr;
        r_bit <= n_bit;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_oldest <= '0;
            r_valid <= 1'b0;
            r_in_en <= 1'b1;
            r_out_en <= 1'b1;
            r_chance <= 14'd1000;
            r_limit <= 7'd5;
            r_delay <= 11'd200;
            r_rng <= RNG_BITS'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oldest <= n_oldest;
            r_valid <= n_valid;
            r_rng <= n_rng;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IN_EN: r_in_en <= i_cfg_data[0];
                    REG_OUT_EN: r_out_en <= i_cfg_data[0];
                    REG_CHANCE: r_chance <= i_cfg_data[13:0];
                    REG_LIMIT: r_limit <= i_cfg_data[6:0];
                    REG_DELAY: r_delay <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_out = r_out;

    `PRHB_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(MAX_HELD))
    `PRHB_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n, o_valid && !o_out.has_packet, o_out.last)
    `PRHB_ASSERT_IMPLY(a_more_means_busy, i_clk, i_rst_n, o_valid && !o_out.last, busy)
    `PRHB_ASSERT_NEXT(a_release_empties, i_clk, i_rst_n, busy, r_count == '0)
endmodule
`default_nettype wire

@@ tb/packet_reorder_hold_buffer_core_tb.sv @@
// Self-checking testbench for the packet reorder hold buffer core.
// Depends on prhb_pkg and the core; predicts every result with its own model.
`timescale 1ns / 1ps
`default_nettype none

class hold_buffer_scoreboard;
    bit in_en;
    bit out_en;
    logic [13:0] chance;
    logic [6:0] limit_reg;
    logic [10:0] delay;
    logic [31:0] rng;
    logic [15:0] tags[64];
    bit dirs[64];
    int unsigned count;
    logic [31:0] oldest;
    prhb_pkg::t_out_item pending[$];
    int errors;

    function void reset_state();
        in_en = 1;
        out_en = 1;
        chance = 1000;
        limit_reg = 5;
        delay = 200;
        rng = 1;
        count = 0;
        oldest = 0;
        pending.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            prhb_pkg::REG_IN_EN: in_en = data[0];
            prhb_pkg::REG_OUT_EN: out_en = data[0];
            prhb_pkg::REG_CHANCE: chance = data[13:0];
            prhb_pkg::REG_LIMIT: limit_reg = data[6:0];
            prhb_pkg::REG_DELAY: delay = data[10:0];
            prhb_pkg::REG_SEED: rng = data;
            default: ;
        endcase
    endfunction

    function void push(bit has, logic [15:0] tag, bit dir, bit hold, bit still, bit lst);
        prhb_pkg::t_out_item r;
        r.has_packet = has;
        r.out_tag = tag;
        r.out_outbound = dir;
        r.from_hold = hold;
        r.still_holding = still;
        r.last = lst;
        pending.push_back(r);
    endfunction

    function void note_item(prhb_pkg::t_in_item it);
        int unsigned lim;
        int unsigned n;
        int unsigned j;
        bit en;
        logic [15:0] t;
        bit d;
        lim = (limit_reg > 64) ? 64 : limit_reg;
        n = count;
        case (it.cmd)
            prhb_pkg::CMD_ARRIVE: begin
                en = it.is_outbound ? out_en : in_en;
                if (count < lim && en && it.capture_roll < chance) begin
                    if (count == 0) oldest = it.now_ms;
                    tags[count] = it.packet_tag;
                    dirs[count] = it.is_outbound;
                    count++;
                    push(0, 0, 0, 0, 1, 1);
                end else begin
                    push(1, it.packet_tag, it.is_outbound, 0, count != 0, 1);
                end
            end
            prhb_pkg::CMD_POLL: begin
                if (n == 0 || !(n >= lim || (it.now_ms - oldest) >= {21'd0, delay})) begin
                    push(0, 0, 0, 0, n != 0, 1);
                end else begin
                    for (int i = n - 1; i > 0; i--) begin
                        rng ^= rng << 13;
                        rng ^= rng >> 17;
                        rng ^= rng << 5;
                        j = rng % (i + 1);
                        t = tags[i];
                        d = dirs[i];
                        tags[i] = tags[j];
                        dirs[i] = dirs[j];
                        tags[j] = t;
                        dirs[j] = d;
                    end
                    count = 0;
                    for (int i = n - 1; i >= 0; i--) push(1, tags[i], dirs[i], 1, 0, i == 0);
                end
            end
            prhb_pkg::CMD_FLUSH: begin
                if (n == 0) begin
                    push(0, 0, 0, 0, 0, 1);
                end else begin
                    count = 0;
                    for (int i = 0; i < n; i++) push(1, tags[i], dirs[i], 1, 0, i == n - 1);
                end
            end
            default: push(0, 0, 0, 0, count != 0, 1);
        endcase
    endfunction

    function void check_result(prhb_pkg::t_out_item got);
        prhb_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            errors++;
        end
    endfunction
endclass

module packet_reorder_hold_buffer_core_tb;
    import prhb_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    t_in_item in_item = '0;
    logic busy;
    logic o_valid;
    t_out_item out_item;
    logic cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic [31:0] clock_ms = 0;
    hold_buffer_scoreboard sb;

    packet_reorder_hold_buffer_core u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .start(start),
        .i_in(in_item),
        .busy(busy),
        .o_valid(o_valid),
        .o_out(out_item),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk) begin
        if (rst_n && o_valid) sb.check_result(out_item);
    end

    // start stays high after an item so that the next one can follow at once;
    // gaps and draining lower it.
    task automatic send_item(t_in_item it);
        start <= 1;
        in_item <= it;
        do @(posedge clk); while (busy);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (g > 0) begin
            start <= 0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    function automatic t_in_item make_item(logic [1:0] cmd, logic [15:0] tag, bit dir,
                                           logic [13:0] roll, logic [31:0] now);
        t_in_item it;
        it.cmd = cmd;
        it.packet_tag = tag;
        it.is_outbound = dir;
        it.capture_roll = roll;
        it.now_ms = now;
        return it;
    endfunction

    task automatic random_phase(int items, bit burst);
        t_in_item it;
        int unsigned r;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            clock_ms += $urandom_range(0, 60);
            if ($urandom_range(0, 30) == 0) clock_ms = $urandom;
            if (r < 65) begin
                it = make_item(CMD_ARRIVE, 16'($urandom), 1'($urandom_range(0, 1)),
                               14'($urandom_range(0, 9999)), clock_ms);
                if ($urandom_range(0, 15) == 0)
                    it.capture_roll = 14'($urandom_range(0, 16383));
            end else if (r < 88) begin
                it = make_item(CMD_POLL, 16'($urandom), 1'($urandom_range(0, 1)),
                               14'($urandom), clock_ms);
            end else if (r < 97) begin
                it = make_item(CMD_FLUSH, 16'($urandom), 1'($urandom_range(0, 1)),
                               14'($urandom), clock_ms);
            end else begin
                it = make_item(CMD_RESERVED, 16'($urandom), 1'($urandom_range(0, 1)),
                               14'($urandom), clock_ms);
            end
            send_item(it);
            if (!burst) random_gap();
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        send_item(make_item(CMD_FLUSH, 0, 0, 0, 0));
        send_item(make_item(CMD_POLL, 0, 0, 0, 0));
        send_item(make_item(CMD_ARRIVE, 16'hFFFF, 1, 0, 32'hFFFF_FFF0));
        send_item(make_item(CMD_ARRIVE, 16'h0000, 0, 999, 32'hFFFF_FFF8));
        send_item(make_item(CMD_ARRIVE, 16'hA5A5, 0, 1000, 32'hFFFF_FFF9));
        send_item(make_item(CMD_ARRIVE, 16'h5A5A, 1, 14'h3FFF, 0));
        send_item(make_item(CMD_RESERVED, 16'hFFFF, 1, 14'h3FFF, 32'hFFFF_FFFF));
        send_item(make_item(CMD_POLL, 0, 0, 0, 32'd100));
        send_item(make_item(CMD_POLL, 0, 0, 0, 32'd200));
        send_item(make_item(CMD_ARRIVE, 16'h1234, 1, 0, 32'd300));
        send_item(make_item(CMD_ARRIVE, 16'h4321, 0, 0, 32'd301));
        send_item(make_item(CMD_FLUSH, 0, 0, 0, 32'd302));
        for (int k = 0; k < 6; k++)
            send_item(make_item(CMD_ARRIVE, 16'(k * 16'h2222), k[0], 0, 400));
        send_item(make_item(CMD_POLL, 0, 0, 0, 32'd401));
        drain();

        set_reg(REG_IN_EN, 0);
        set_reg(REG_OUT_EN, 1);
        set_reg(REG_CHANCE, 10000);
        set_reg(REG_LIMIT, 64);
        set_reg(REG_DELAY, 2000);
        set_reg(REG_SEED, 32'hFFFF_FFFF);
        for (int k = 0; k < 66; k++)
            send_item(make_item(CMD_ARRIVE, 16'($urandom), 1,
                                14'($urandom_range(0, 9999)), 500));
        send_item(make_item(CMD_POLL, 0, 0, 0, 32'd501));
        drain();

        set_reg(REG_IN_EN, 1);
        set_reg(REG_CHANCE, 7000);
        set_reg(REG_LIMIT, 8);
        set_reg(REG_DELAY, 10);
        set_reg(REG_SEED, $urandom | 1);
        random_phase(50, 0);
        drain();

        set_reg(REG_LIMIT, 127);
        set_reg(REG_CHANCE, 9000);
        set_reg(REG_DELAY, 300);
        set_reg(REG_SEED, 0);
        random_phase(35, 1);
        drain();

        set_reg(REG_OUT_EN, 0);
        set_reg(REG_CHANCE, 0);
        set_reg(REG_LIMIT, 2);
        random_phase(15, 0);
        drain();

        set_reg(REG_OUT_EN, 1);
        set_reg(REG_CHANCE, 5000);
        set_reg(REG_LIMIT, 12);
        set_reg(REG_DELAY, 150);
        set_reg(REG_SEED, $urandom | 1);
        random_phase(45, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("packet_reorder_hold_buffer_core_tb: done, clean");
        end else begin
            $display("packet_reorder_hold_buffer_core_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("packet_reorder_hold_buffer_core_tb: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
